>>> rtl/assert_macros.svh
// Assertion macros shared by the transmit queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Trigger in this cycle implies a consequence in the next cycle.
`define CTQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> rtl/ctq_pkg.sv
// Types and constants for the CAN frame transmit queue.
`timescale 1ns / 1ps
package ctq_pkg;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;

  localparam logic [10:0] ID_MAX  = 11'h7FF;
  localparam logic [3:0]  LEN_MAX = 4'd8;
  localparam int          FILL_W  = 7;
  localparam int          HDR_W   = 15;

  localparam logic [2:0] ST_PUSHED  = 3'd0;
  localparam logic [2:0] ST_BAD_ID  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_POPPED  = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;
  localparam logic [2:0] ST_DROPPED = 3'd6;

  typedef struct packed {
    logic        operation;
    logic [28:0] push_id;
    logic [3:0]  push_length;
    logic [63:0] push_payload;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [10:0]       pop_id;
    logic [3:0]        pop_length;
    logic [63:0]       pop_payload;
    logic [FILL_W-1:0] fill_count;
  } rsp_t;

  // Result of one accepted operation, waiting on the frame store read.
  typedef struct packed {
    logic              pop_read;
    logic [2:0]        status;
    logic [FILL_W-1:0] fill;
  } pend_t;

endpackage

>>> rtl/ctq_store.sv
// Frame store: header and payload memories, one write and one registered read port.
`timescale 1ns / 1ps
module ctq_store #(
  parameter int QUEUE_DEPTH = 64,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [ctq_pkg::HDR_W-1:0]  wr_hdr,
  input  logic [63:0]                wr_pay,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [ctq_pkg::HDR_W-1:0]  rd_hdr,
  output logic [63:0]                rd_pay
);
  import ctq_pkg::*;

  logic [HDR_W-1:0] hdr_mem [QUEUE_DEPTH];
  logic [63:0]      pay_mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_hdr;
      pay_mem[wr_addr] <= wr_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hdr <= hdr_mem[rd_addr];
      rd_pay <= pay_mem[rd_addr];
    end
  end

endmodule

>>> rtl/ctq_ctrl.sv
// Queue control: pointers, fill count, push checks and store access.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctq_ctrl #(
  parameter int QUEUE_DEPTH = 64,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  ctq_pkg::req_t              req,
  output ctq_pkg::pend_t             pend,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [ctq_pkg::HDR_W-1:0]  wr_hdr,
  output logic [63:0]                wr_pay,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr
);
  import ctq_pkg::*;

  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = (CW > FILL_W) ? CW : FILL_W;
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [AW-1:0]    rd_ptr, rd_ptr_next;
  logic [AW-1:0]    wr_ptr, wr_ptr_next;
  logic [CW-1:0]    count, count_next;
  logic [EXT_W-1:0] count_ext;
  logic             id_ok, len_ok, full, empty;
  logic [2:0]       status;

  always_comb begin
    id_ok  = (req.push_id != '0) && (req.push_id <= 29'(ID_MAX));
    len_ok = req.push_length <= LEN_MAX;
    full   = count == CNT_FULL;
    empty  = count == '0;

    wr_en  = 1'b0;
    rd_en  = 1'b0;
    status = ST_PUSHED;
    if (req.operation == OP_PUSH) begin
      if (!id_ok) begin
        status = ST_BAD_ID;
      end else if (!len_ok) begin
        status = ST_BAD_LEN;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status = ST_PUSHED;
        wr_en  = accept;
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        // final code (popped or dropped) is settled once the header is read
        status = ST_POPPED;
        rd_en  = accept;
      end
    end

    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (wr_en) begin
      wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      count_next  = count + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end

    count_ext     = EXT_W'(count_next);
    pend.pop_read = (req.operation == OP_POP) && !empty;
    pend.status   = status;
    pend.fill     = count_ext[FILL_W-1:0];
  end

  assign wr_addr = wr_ptr;
  assign wr_hdr  = {req.push_length, req.push_id[10:0]};
  assign wr_pay  = req.push_payload;
  assign rd_addr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  `CTQ_ASSERT(a_cnt_range, count <= CNT_FULL, "fill count above queue depth")
  `CTQ_ASSERT(a_empty_ptrs, (count != '0) || (rd_ptr == wr_ptr), "empty queue with split pointers")
  `CTQ_ASSERT(a_one_port, !(wr_en && rd_en), "store written and read in one cycle")
  `CTQ_ASSERT_NEXT(a_push_cnt, wr_en, count == CW'($past(count) + 1'b1), "push did not count up")

endmodule

>>> rtl/can_frame_tx_queue_core.sv
// Top level of the CAN frame transmit queue: handshake, pending stage and result register.
//
//  channel | signals                  | dir | beat
//  --------+--------------------------+-----+-----------------------------------
//  req     | req_valid, req_stall, req | in  | one push or pop (ctq_pkg::req_t)
//  rsp     | rsp_valid, rsp_stall, rsp | out | one result (ctq_pkg::rsp_t)
//
// One operation per cycle is taken while the result side keeps draining.
// A result passes through the pending stage, alongside the registered frame store
// read, and then through the result register.
// rst is synchronous; the queue comes up empty, store contents are not cleared.
// rsp_stall holds the result register, then the pending stage, then req_stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module can_frame_tx_queue_core #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ctq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ctq_pkg::rsp_t rsp
);
  import ctq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic             accept;
  logic             s1_valid, s1_move, out_free;
  pend_t            pend, s1;
  rsp_t             rsp_next;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [HDR_W-1:0] wr_hdr, rd_hdr;
  logic [63:0]      wr_pay, rd_pay;
  logic [3:0]       rd_len;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_move   = s1_valid && out_free;
  assign req_stall = s1_valid && !s1_move;
  assign accept    = req_valid && !req_stall;

  ctq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .pend    (pend),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_hdr  (wr_hdr),
    .wr_pay  (wr_pay),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  ctq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_hdr  (wr_hdr),
    .wr_pay  (wr_pay),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_hdr  (rd_hdr),
    .rd_pay  (rd_pay)
  );

  assign rd_len = rd_hdr[14:11];

  always_comb begin
    rsp_next             = '0;
    rsp_next.fill_count  = s1.fill;
    rsp_next.status      = s1.status;
    if (s1.pop_read) begin
      // zero-length frames leave the queue but are not sent
      if (rd_len == '0) begin
        rsp_next.status = ST_DROPPED;
      end else begin
        rsp_next.status      = ST_POPPED;
        rsp_next.pop_id      = rd_hdr[10:0];
        rsp_next.pop_length  = rd_len;
        rsp_next.pop_payload = rd_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= pend;
    end
    if (s1_move) begin
      rsp <= rsp_next;
    end
  end

  `CTQ_ASSERT(a_pop_len, !rsp_valid || (rsp.status != ST_POPPED) || ((rsp.pop_length != '0) && (rsp.pop_length <= LEN_MAX)), "popped frame with bad length")
  `CTQ_ASSERT_NEXT(a_rd_follows, rd_en, s1_valid && s1.pop_read, "store read without pending pop")

endmodule

>>> test/tb.sv
// Self-checking bench for the CAN frame transmit queue: predicted results, random traffic, stalls.
`timescale 1ns / 1ps
module tb;
  import ctq_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int PIPE_LATENCY   = 2;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  can_frame_tx_queue_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // Shadow copy of the queue
  logic [10:0] held_id   [QUEUE_DEPTH];
  logic [3:0]  held_len  [QUEUE_DEPTH];
  logic [63:0] held_data [QUEUE_DEPTH];
  int unsigned head;
  int unsigned tail;
  int unsigned frames_held;
  int unsigned peak_fill;
  int unsigned status_tally [8];

  rsp_t predicted_rsp [$];
  int unsigned failures;
  int unsigned results_checked;

  bit sender_idles;
  bit rsp_idles;
  bit long_hold_req;
  int unsigned quiet_cycles;

  function automatic rsp_t predict_queue_op(input req_t op);
    rsp_t res;
    res = '0;
    if (op.operation == OP_PUSH) begin
      if (op.push_id == 0 || op.push_id > ID_MAX) begin
        res.status = ST_BAD_ID;
      end else if (op.push_length > LEN_MAX) begin
        res.status = ST_BAD_LEN;
      end else if (frames_held >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        held_id[tail]   = op.push_id[10:0];
        held_len[tail]  = op.push_length;
        held_data[tail] = op.push_payload;
        tail = (tail + 1) % QUEUE_DEPTH;
        frames_held++;
        res.status = ST_PUSHED;
      end
    end else begin
      if (frames_held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // zero-length frames leave the queue but are not sent
        if (held_len[head] == 0) begin
          res.status = ST_DROPPED;
        end else begin
          res.status      = ST_POPPED;
          res.pop_id      = held_id[head];
          res.pop_length  = held_len[head];
          res.pop_payload = held_data[head];
        end
        head = (head + 1) % QUEUE_DEPTH;
        frames_held--;
      end
    end
    res.fill_count = frames_held[FILL_W-1:0];
    if (frames_held > peak_fill) peak_fill = frames_held;
    status_tally[res.status]++;
    return res;
  endfunction

  // Random push or pop; push_weight is the percentage of pushes.
  function automatic req_t random_frame_op(input int unsigned push_weight);
    req_t op;
    int unsigned pick;
    op.operation    = ($urandom_range(0, 99) < push_weight) ? OP_PUSH : OP_POP;
    op.push_id      = 29'($urandom_range(1, ID_MAX));
    op.push_length  = 4'($urandom_range(1, LEN_MAX));
    op.push_payload = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 6)       op.push_length = 4'd0;
    else if (pick < 10) op.push_length = 4'($urandom_range(LEN_MAX + 1, 15));
    else if (pick < 11) op.push_id = '0;
    else if (pick < 14) op.push_id = 29'($urandom_range(ID_MAX + 1, 29'h1FFF_FFFF));
    else if (pick < 15) op.push_payload = '1;
    else if (pick < 16) op.push_payload = '0;
    else if (pick < 18) op.push_id = 29'(ID_MAX);
    return op;
  endfunction

  function automatic req_t frame_op(input logic operation, input logic [28:0] id,
                                    input logic [3:0] len, input logic [63:0] data);
    req_t op;
    op.operation    = operation;
    op.push_id      = id;
    op.push_length  = len;
    op.push_payload = data;
    return op;
  endfunction

  task automatic send_op(input req_t op);
    int unsigned gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predicted_rsp.push_back(predict_queue_op(op));
  endtask

  task automatic test_directed();
    send_op(frame_op(OP_POP, 29'd0, 4'd0, 64'd0));
    send_op(frame_op(OP_PUSH, 29'd0, 4'd3, 64'h1122));
    send_op(frame_op(OP_PUSH, 29'h800, 4'd3, 64'h1122));
    send_op(frame_op(OP_PUSH, 29'h1FFF_FFFF, 4'd15, '1));
    send_op(frame_op(OP_PUSH, 29'd0, 4'd15, '1));
    send_op(frame_op(OP_PUSH, 29'h7FF, 4'd9, '1));
    send_op(frame_op(OP_PUSH, 29'd1, 4'd15, '1));
    send_op(frame_op(OP_PUSH, 29'd1, 4'd0, '1));
    send_op(frame_op(OP_PUSH, 29'h7FF, 4'd8, '1));
    send_op(frame_op(OP_PUSH, 29'h555, 4'd8, 64'd0));
    send_op(frame_op(OP_PUSH, 29'h2AA, 4'd1, 64'h8000_0000_0000_0001));
    send_op(frame_op(OP_POP, '1, 4'd15, '1));
    send_op(frame_op(OP_POP, 29'd0, 4'd0, 64'd0));
    send_op(frame_op(OP_POP, 29'd0, 4'd0, 64'd0));
    send_op(frame_op(OP_POP, 29'd0, 4'd0, 64'd0));
    send_op(frame_op(OP_POP, 29'd0, 4'd0, 64'd0));
  endtask

  // Fill to the top, check reject precedence while full, then drain past empty.
  task automatic test_fill_and_drain();
    req_t op;
    while (frames_held < QUEUE_DEPTH) begin
      op = random_frame_op(100);
      op.push_id     = 29'($urandom_range(1, ID_MAX));
      op.push_length = 4'($urandom_range(0, LEN_MAX));
      send_op(op);
    end
    send_op(frame_op(OP_PUSH, 29'h7FF, 4'd8, '1));
    send_op(frame_op(OP_PUSH, 29'd0, 4'd8, '1));
    send_op(frame_op(OP_PUSH, 29'h100, 4'd12, '1));
    while (frames_held > 0) send_op(random_frame_op(0));
    send_op(random_frame_op(0));
  endtask

  task automatic test_backpressure();
    sender_idles  = 1'b0;
    rsp_idles     = 1'b0;
    long_hold_req = 1'b1;
    repeat (120) send_op(random_frame_op(60));
  endtask

  task automatic test_random_mix();
    int unsigned weight;
    for (int seg = 0; seg < 15; seg++) begin
      case ($urandom_range(0, 2))
        0: weight = 80;
        1: weight = 20;
        default: weight = 50;
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      rsp_idles    = ($urandom_range(0, 3) != 0);
      repeat (100) send_op(random_frame_op(weight));
    end
  endtask

  task automatic test_random_steady();
    sender_idles = 1'b0;
    rsp_idles    = 1'b0;
    repeat (200) send_op(random_frame_op(55));
  endtask

  // Result side stall pattern
  initial begin : rsp_side
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (rsp_idles && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic void compare_field(input string name, input logic [63:0] exp,
                                        input logic [63:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t exp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (predicted_rsp.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %h", $time, rsp);
        failures++;
      end else begin
        exp = predicted_rsp.pop_front();
        compare_field("status", 64'(exp.status), 64'(rsp.status));
        compare_field("pop_id", 64'(exp.pop_id), 64'(rsp.pop_id));
        compare_field("pop_length", 64'(exp.pop_length), 64'(rsp.pop_length));
        compare_field("pop_payload", exp.pop_payload, rsp.pop_payload);
        compare_field("fill_count", 64'(exp.fill_count), 64'(rsp.fill_count));
        results_checked++;
      end
    end
  end

  // Give up when neither side moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, predicted_rsp.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    req_valid    = 1'b0;
    req          = '0;
    head         = 0;
    tail         = 0;
    frames_held  = 0;
    peak_fill    = 0;
    failures     = 0;
    quiet_cycles = 0;
    sender_idles = 1'b0;
    rsp_idles    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();
    test_random_steady();

    req_valid <= 1'b0;
    while (predicted_rsp.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 6) @(posedge clk);
    if (predicted_rsp.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, predicted_rsp.size());
      failures++;
    end

    $display("Checked %0d results: %0d pushed, %0d bad id, %0d bad length, %0d full,",
             results_checked, status_tally[ST_PUSHED], status_tally[ST_BAD_ID],
             status_tally[ST_BAD_LEN], status_tally[ST_FULL]);
    $display("  %0d popped, %0d empty, %0d dropped; peak fill %0d of %0d",
             status_tally[ST_POPPED], status_tally[ST_EMPTY], status_tally[ST_DROPPED],
             peak_fill, QUEUE_DEPTH);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
